>>> hdl/scel_pkg.sv
// shared types and constants for the sparse column entry lookup block
// item and result words, controller/datapath command and status structs
// no dependencies
package scel_pkg;

	// storage sizes
	localparam int NUM_MATRICES = 4;
	localparam int MAX_COLUMNS  = 256;
	localparam int MAX_ENTRIES  = 4096;

	// field widths
	localparam int MAT_W = 2;
	localparam int COL_W = 9;
	localparam int ROW_W = 8;
	localparam int POS_W = 12;
	localparam int PTR_W = 13;
	localparam int VAL_W = 64;

	// memory depths and address widths
	localparam int PTR_DEPTH = NUM_MATRICES * (2 ** COL_W);
	localparam int PTR_AW    = $clog2(PTR_DEPTH);
	localparam int ENT_DEPTH = NUM_MATRICES * (2 ** POS_W);
	localparam int ENT_AW    = $clog2(ENT_DEPTH);

	// item operation codes
	typedef enum logic [1:0] {
		MODE_LOAD_PTR   = 2'd0,
		MODE_LOAD_ENTRY = 2'd1,
		MODE_LOOKUP     = 2'd2,
		MODE_UPDATE     = 2'd3
	} mode_t;

	// input word
	typedef struct packed {
		mode_t                     mode;
		logic [MAT_W-1:0]          matrix_level;
		logic [COL_W-1:0]          col_index;
		logic [ROW_W-1:0]          row_index;
		logic [POS_W-1:0]          position;
		logic [PTR_W-1:0]          pointer_value;
		logic signed [VAL_W-1:0]   entry_value;
	} item_t;

	// output word
	typedef struct packed {
		logic                      found;
		logic signed [VAL_W-1:0]   value_out;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic take;       // latch the incoming word
		logic exec;       // do loads, fetch the column start pointer
		logic rd_ptr_hi;  // fetch the column end pointer
		logic init;       // set up the search range, first row read
		logic step;       // one bisection step, next row read
		logic hit;        // row matched: read or write the value
		logic hit_mid;    // matched slot is mid, else lo
		logic out_load;   // move the result into the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		mode_t mode;
		logic  addr_ok;   // matrix and column in range for a search
		logic  empty;     // column range is empty or inverted
		logic  row_eq;    // row just read equals the row sought
		logic  cont;      // new range still has a midpoint above lo
		logic  out_free;  // output register can take a result
		logic  found;     // a match was seen for this word
	} sts_t;

endpackage

>>> hdl/scel_datapath.sv
// datapath: item register, pointer/row/value memories, bisection range
// registers and the output register
// depends on scel_pkg
module scel_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  scel_pkg::item_t   item,
	input  scel_pkg::cmd_t    cmd,
	output scel_pkg::sts_t    sts,
	input  logic              result_ready,
	output logic              result_valid,
	output scel_pkg::result_t result
);
	import scel_pkg::*;

	// storage
	logic [PTR_W-1:0] ptr_mem [PTR_DEPTH];
	logic [ROW_W-1:0] row_mem [ENT_DEPTH];
	logic [VAL_W-1:0] val_mem [ENT_DEPTH];

	item_t            item_q;
	logic [PTR_W-1:0] lo_q, hi_q, mid_q;
	logic [PTR_W-1:0] ptr_rd_q;
	logic [ROW_W-1:0] row_rd_q;
	logic [VAL_W-1:0] val_rd_q;
	logic             hit_q;
	logic             result_valid_q;
	result_t          result_q;

	logic             mat_ok, addr_ok, ptr_wr_ok, ent_wr_ok;
	logic [COL_W-1:0] col_next;
	logic [PTR_AW-1:0] ptr_addr;
	logic [PTR_W-1:0] hi_sat;
	logic             row_lt, row_eq;
	logic [PTR_W-1:0] nlo, nhi, nmid, rd_slot, hit_slot;
	logic [PTR_W:0]   range_sum;
	logic             cont;
	logic [ENT_AW-1:0] row_addr, ent_wr_addr, val_addr, val_wr_addr;
	logic             ld_ptr, ld_ent, upd_wr, val_rd_en;

	// range checks
	always_comb begin
		mat_ok    = int'(item_q.matrix_level) < NUM_MATRICES;
		addr_ok   = mat_ok && (int'(item_q.col_index) < MAX_COLUMNS);
		ptr_wr_ok = mat_ok && (int'(item_q.col_index) <= MAX_COLUMNS);
		ent_wr_ok = mat_ok && (int'(item_q.position) < MAX_ENTRIES);
	end

	// pointer memory address: start slot, or end slot on the second fetch
	assign col_next = item_q.col_index + COL_W'(1);
	assign ptr_addr = PTR_AW'({item_q.matrix_level,
		(cmd.rd_ptr_hi ? col_next : item_q.col_index)});

	// end pointer saturates at the entry count
	assign hi_sat = (int'(ptr_rd_q) > MAX_ENTRIES) ? PTR_W'(MAX_ENTRIES) : ptr_rd_q;

	// row compare against the sought row
	assign row_lt = row_rd_q < item_q.row_index;
	assign row_eq = row_rd_q == item_q.row_index;

	// next range: narrow by the last compare, or start from the pointers
	always_comb begin
		if (cmd.step) begin
			if (row_lt) begin
				nlo = mid_q;
				nhi = hi_q;
			end else begin
				nlo = lo_q;
				nhi = mid_q;
			end
		end else begin
			nlo = lo_q;
			nhi = hi_sat;
		end
		range_sum = {1'b0, nlo} + {1'b0, nhi};
		nmid      = range_sum[PTR_W:1];
		cont      = nlo < nmid;
		rd_slot   = cont ? nmid : nlo;
	end

	// entry memory addresses
	assign hit_slot    = cmd.hit_mid ? mid_q : lo_q;
	assign row_addr    = ENT_AW'({item_q.matrix_level, rd_slot[POS_W-1:0]});
	assign val_addr    = ENT_AW'({item_q.matrix_level, hit_slot[POS_W-1:0]});
	assign ent_wr_addr = ENT_AW'({item_q.matrix_level, item_q.position});
	assign val_wr_addr = cmd.hit ? val_addr : ent_wr_addr;

	// write and read enables
	assign ld_ptr    = cmd.exec && (item_q.mode == MODE_LOAD_PTR) && ptr_wr_ok;
	assign ld_ent    = cmd.exec && (item_q.mode == MODE_LOAD_ENTRY) && ent_wr_ok;
	assign upd_wr    = cmd.hit && (item_q.mode == MODE_UPDATE);
	assign val_rd_en = cmd.hit && (item_q.mode == MODE_LOOKUP);

	// column pointer memory
	always_ff @(posedge clk) begin
		if (ld_ptr) begin
			ptr_mem[ptr_addr] <= item_q.pointer_value;
		end
		if (cmd.exec || cmd.rd_ptr_hi) begin
			ptr_rd_q <= ptr_mem[ptr_addr];
		end
	end

	// entry row memory
	always_ff @(posedge clk) begin
		if (ld_ent) begin
			row_mem[ent_wr_addr] <= item_q.row_index;
		end
		if (cmd.init || cmd.step) begin
			row_rd_q <= row_mem[row_addr];
		end
	end

	// entry value memory
	always_ff @(posedge clk) begin
		if (ld_ent || upd_wr) begin
			val_mem[val_wr_addr] <= item_q.entry_value;
		end
		if (val_rd_en) begin
			val_rd_q <= val_mem[val_addr];
		end
	end

	// item and search range registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			item_q <= item;
		end
		if (cmd.rd_ptr_hi) begin
			lo_q <= ptr_rd_q;
		end else if (cmd.init || cmd.step) begin
			lo_q <= nlo;
		end
		if (cmd.init || cmd.step) begin
			hi_q  <= nhi;
			mid_q <= nmid;
		end
	end

	// match flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.take) begin
			hit_q <= 1'b0;
		end else if (cmd.hit) begin
			hit_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_q.found     <= hit_q;
			result_q.value_out <= (hit_q && (item_q.mode == MODE_LOOKUP)) ?
				val_rd_q : '0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// status
	always_comb begin
		sts.mode     = item_q.mode;
		sts.addr_ok  = addr_ok;
		sts.empty    = lo_q >= hi_sat;
		sts.row_eq   = row_eq;
		sts.cont     = cont;
		sts.out_free = !result_valid_q || result_ready;
		sts.found    = hit_q;
	end

endmodule

>>> hdl/scel_ctrl.sv
// controller: sequences loads, pointer fetches, the bisection and the
// hand-off to the output register
// depends on scel_pkg
module scel_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  scel_pkg::sts_t sts,
	output scel_pkg::cmd_t cmd
);
	import scel_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_EXEC     = 7'b0000010,
		ST_PTR_HI   = 7'b0000100,
		ST_PTR_WAIT = 7'b0001000,
		ST_SEARCH   = 7'b0010000,
		ST_FINAL    = 7'b0100000,
		ST_RESULT   = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   is_search;

	assign is_search = sts.mode inside {MODE_LOOKUP, MODE_UPDATE};

	// next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (is_search && sts.addr_ok) begin
					state_d = ST_PTR_HI;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_PTR_HI: begin
				cmd.rd_ptr_hi = 1'b1;
				state_d       = ST_PTR_WAIT;
			end
			ST_PTR_WAIT: begin
				if (sts.empty) begin
					state_d = ST_RESULT;
				end else begin
					cmd.init = 1'b1;
					state_d  = sts.cont ? ST_SEARCH : ST_FINAL;
				end
			end
			ST_SEARCH: begin
				if (sts.row_eq) begin
					cmd.hit     = 1'b1;
					cmd.hit_mid = 1'b1;
					state_d     = ST_RESULT;
				end else begin
					cmd.step = 1'b1;
					state_d  = sts.cont ? ST_SEARCH : ST_FINAL;
				end
			end
			ST_FINAL: begin
				cmd.hit = sts.row_eq;
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hdl/sparse_column_entry_lookup_top.sv
// top level of the sparse column entry lookup block
// instantiates scel_ctrl and scel_datapath, depends on scel_pkg
//
// Holds four sparse matrices in compressed-column form: per matrix 257
// column start pointers and 4096 entry slots (8-bit row, 64-bit value),
// none of which is cleared by reset, so every slot a search touches must
// be loaded first. One word is worked on at a time; a finished result sits
// in an output register, so the next word is taken while it waits. Lookup
// and update words fetch the column start and end pointers, then take one
// bisection step per read of the entry row memory, which is read once a
// cycle, until a row matches or the range runs out. Out of range matrix or
// column numbers give found=0.
module sparse_column_entry_lookup_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  scel_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output scel_pkg::result_t result
);
	import scel_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	scel_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// storage and search datapath
	scel_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.result       (result)
	);

	// a result only moves into a free output register
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded over a pending word");

	// value access only for lookup and update words
	a_hit_mode: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hit |-> (sts.mode == MODE_LOOKUP || sts.mode == MODE_UPDATE))
		else $error("match signaled on a load word");

	// an accepted word is executed in the next cycle
	a_take_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> cmd.exec)
		else $error("accepted word not executed");

	// a miss always yields a zero value
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && !sts.found) |=>
			(result_valid && !result.found && result.value_out == '0))
		else $error("miss result not cleared");

endmodule
